/* rtl/fpa_pkg.sv */
// shared widths, command codes and compare codes for the q64.48 alu
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int INT_W  = 64;
  localparam int FRAC_W = 48;
  localparam int FX_W   = INT_W + FRAC_W;

  // multiplier is split into limbs of this size
  localparam int LIMB_W = 28;
  localparam int NLIMB  = FX_W / LIMB_W;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int COL_W  = PP_W + 2;
  localparam int NCOL   = 2 * NLIMB - 1;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEG = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CMP = 3'd5;

  localparam int ORD_W = 2;
  localparam logic [ORD_W-1:0] ORD_EQ = 2'd0;
  localparam logic [ORD_W-1:0] ORD_GT = 2'd1;
  localparam logic [ORD_W-1:0] ORD_LT = 2'd2;

endpackage

/* rtl/fixed_point_64_48_alu.sv */
// q64.48 fixed-point alu: add, subtract, multiply, negate, absolute value, compare
//
// Input beats carry a command and two operands, each split into a signed 64-bit
// integer part and an unsigned 48-bit fraction part. Each input beat gives one
// result beat (integer part, fraction part, compare order), in input order.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The block is a six-stage pipeline: operand prep and the short operations,
// 28x28 partial products, column sums, two partial accumulations, the final
// 160-bit add, then sign restore into the output register. One beat is accepted
// every cycle unless in_stall is high.
// The multiplier sets the depth; all commands take the same path so results
// stay in order.
// When the receiver stalls, the output register holds its beat and empty
// stages behind it keep filling; in_stall rises only once every stage is full.
// Reset (rst_n low at a clock edge) empties the pipeline; the data registers are not reset.
`timescale 1ns / 1ps

module fixed_point_64_48_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpa_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [fpa_pkg::INT_W-1:0]  in_a_int,
  input  logic [fpa_pkg::FRAC_W-1:0]        in_a_frac,
  input  logic signed [fpa_pkg::INT_W-1:0]  in_b_int,
  input  logic [fpa_pkg::FRAC_W-1:0]        in_b_frac,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fpa_pkg::INT_W-1:0]  out_r_int,
  output logic [fpa_pkg::FRAC_W-1:0]        out_r_frac,
  output logic [fpa_pkg::ORD_W-1:0]         out_order
);

  localparam int FX_W   = fpa_pkg::FX_W;
  localparam int FRAC_W = fpa_pkg::FRAC_W;
  localparam int LIMB_W = fpa_pkg::LIMB_W;
  localparam int NLIMB  = fpa_pkg::NLIMB;
  localparam int PP_W   = fpa_pkg::PP_W;
  localparam int COL_W  = fpa_pkg::COL_W;
  localparam int NCOL   = fpa_pkg::NCOL;
  localparam int NSTG   = 6;
  // low accumulator holds columns 0..3, high one columns 4..6 (only bits below 160 kept)
  localparam int LO_W   = 3 * LIMB_W + COL_W + 1;
  localparam int HI_W   = FRAC_W;
  localparam int PRD_W  = FX_W + FRAC_W;

  typedef logic [FX_W-1:0] fx_t;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: short operations, compare, operand magnitudes
  fx_t a_w, b_w, na_w, nb_w;
  fx_t                       res_nxt;
  logic [fpa_pkg::ORD_W-1:0] ord_nxt;

  assign a_w  = {in_a_int, in_a_frac};
  assign b_w  = {in_b_int, in_b_frac};
  assign na_w = fx_t'(~a_w + fx_t'(1));
  assign nb_w = fx_t'(~b_w + fx_t'(1));

  always_comb begin
    res_nxt = '0;
    ord_nxt = fpa_pkg::ORD_EQ;
    unique case (in_cmd)
      fpa_pkg::CMD_ADD: res_nxt = fx_t'(a_w + b_w);
      fpa_pkg::CMD_SUB: res_nxt = fx_t'(a_w + nb_w);
      fpa_pkg::CMD_NEG: res_nxt = na_w;
      fpa_pkg::CMD_ABS: res_nxt = a_w[FX_W-1] ? na_w : a_w;
      fpa_pkg::CMD_CMP: begin
        if ($signed(a_w) > $signed(b_w)) begin
          ord_nxt = fpa_pkg::ORD_GT;
        end else if ($signed(a_w) < $signed(b_w)) begin
          ord_nxt = fpa_pkg::ORD_LT;
        end
      end
      default: res_nxt = '0;
    endcase
  end

  logic [fpa_pkg::CMD_W-1:0] cmd1_r;
  fx_t                       res1_r, ma1_r, mb1_r;
  logic [fpa_pkg::ORD_W-1:0] ord1_r;
  logic                      sgn1_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd1_r <= in_cmd;
      res1_r <= res_nxt;
      ord1_r <= ord_nxt;
      ma1_r  <= a_w[FX_W-1] ? na_w : a_w;
      mb1_r  <= b_w[FX_W-1] ? nb_w : b_w;
      sgn1_r <= a_w[FX_W-1] ^ b_w[FX_W-1];
    end
  end

  // stage 2: limb partial products
  logic [PP_W-1:0] pp_nxt [NLIMB*NLIMB];
  logic [PP_W-1:0] pp2_r  [NLIMB*NLIMB];
  logic [fpa_pkg::CMD_W-1:0] cmd2_r;
  fx_t                       res2_r;
  logic [fpa_pkg::ORD_W-1:0] ord2_r;
  logic                      sgn2_r;

  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        pp_nxt[i*NLIMB+j] = PP_W'(ma1_r[i*LIMB_W +: LIMB_W]) *
                            PP_W'(mb1_r[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pp2_r  <= pp_nxt;
      cmd2_r <= cmd1_r;
      res2_r <= res1_r;
      ord2_r <= ord1_r;
      sgn2_r <= sgn1_r;
    end
  end

  // stage 3: sum each diagonal of equal weight
  logic [COL_W-1:0] col_nxt [NCOL];
  logic [COL_W-1:0] col3_r  [NCOL];
  logic [fpa_pkg::CMD_W-1:0] cmd3_r;
  fx_t                       res3_r;
  logic [fpa_pkg::ORD_W-1:0] ord3_r;
  logic                      sgn3_r;

  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      col_nxt[k] = '0;
      for (int i = 0; i < NLIMB; i++) begin
        if (k - i >= 0 && k - i < NLIMB) begin
          col_nxt[k] = col_nxt[k] + COL_W'(pp2_r[i*NLIMB + (k - i)]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      col3_r <= col_nxt;
      cmd3_r <= cmd2_r;
      res3_r <= res2_r;
      ord3_r <= ord2_r;
      sgn3_r <= sgn2_r;
    end
  end

  // stage 4: low and high column groups
  logic [LO_W-1:0] lo4_r;
  logic [HI_W-1:0] hi4_r;
  logic [fpa_pkg::CMD_W-1:0] cmd4_r;
  fx_t                       res4_r;
  logic [fpa_pkg::ORD_W-1:0] ord4_r;
  logic                      sgn4_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      lo4_r  <= LO_W'(col3_r[0]) + (LO_W'(col3_r[1]) << LIMB_W) +
                (LO_W'(col3_r[2]) << (2 * LIMB_W)) + (LO_W'(col3_r[3]) << (3 * LIMB_W));
      hi4_r  <= HI_W'(col3_r[4]) + (HI_W'(col3_r[5]) << LIMB_W) +
                (HI_W'(col3_r[6]) << (2 * LIMB_W));
      cmd4_r <= cmd3_r;
      res4_r <= res3_r;
      ord4_r <= ord3_r;
      sgn4_r <= sgn3_r;
    end
  end

  // stage 5: keep product bits 48..159
  logic [PRD_W-1:0] prd_w;
  fx_t  mag5_r;
  logic [fpa_pkg::CMD_W-1:0] cmd5_r;
  fx_t                       res5_r;
  logic [fpa_pkg::ORD_W-1:0] ord5_r;
  logic                      sgn5_r;

  assign prd_w = PRD_W'(lo4_r) + {hi4_r, (FX_W)'(0)};

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      mag5_r <= prd_w[PRD_W-1:FRAC_W];
      cmd5_r <= cmd4_r;
      res5_r <= res4_r;
      ord5_r <= ord4_r;
      sgn5_r <= sgn4_r;
    end
  end

  // stage 6: restore sign, select result into the output register
  fx_t mul_w;
  fx_t out_r;
  logic [fpa_pkg::ORD_W-1:0] ord6_r;

  assign mul_w = sgn5_r ? fx_t'(~mag5_r + fx_t'(1)) : mag5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_r  <= (cmd5_r == fpa_pkg::CMD_MUL) ? mul_w : res5_r;
      ord6_r <= ord5_r;
    end
  end

  assign out_valid  = v_r[NSTG-1];
  assign out_r_int  = out_r[FX_W-1:FRAC_W];
  assign out_r_frac = out_r[FRAC_W-1:0];
  assign out_order  = ord6_r;

endmodule
